// ===== hw/rtl/swap_slot_bitmap_allocator_top_assert.svh =====
// assertion macros for the swap slot bitmap allocator checker
`ifndef SWAP_SLOT_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define SWAP_SLOT_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define SSBA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("ssba: assertion failed");

// next-cycle implication, held off during reset
`define SSBA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("ssba: assertion failed");

`endif

// ===== hw/rtl/ssba_pkg.sv =====
// shared types, constants and helpers of the swap slot bitmap allocator
package ssba_pkg;

	localparam int WORD_BITS = 64;
	localparam int WORD_LSB  = 6;
	localparam int SWAP_W    = 14;
	localparam int INDEX_W   = 13;

	localparam logic [SWAP_W-1:0] SWAP_SECTORS_RESET = 14'd8192;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_RANGE    = 2'd2,
		ST_UNUSED   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_RD0,
		S_RD1,
		S_RD2,
		S_CHK,
		S_WR0,
		S_WR1
	} state_t;

	typedef struct packed {
		logic                hit;
		logic [WORD_LSB-1:0] pos;
	} scan_res_t;

	// lower k lanes of a word enabled
	function automatic logic [WORD_BITS-1:0] lane_mask(input logic [WORD_LSB-1:0] k);
		logic [WORD_BITS-1:0] m;
		for (int i = 0; i < WORD_BITS; i++) begin
			m[i] = (WORD_LSB'(i) < k);
		end
		return m;
	endfunction

endpackage

// ===== hw/rtl/ssba_mem.sv =====
// single-port used-map memory, registered read data
module ssba_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== hw/rtl/ssba_scan.sv =====
// finds the lowest lane of a word where a free run of the page length ends
module ssba_scan
	import ssba_pkg::*;
#(
	parameter int SECTORS_PER_PAGE = 8
) (
	input  logic [WORD_BITS-1:0] prev_free,
	input  logic [WORD_BITS-1:0] cur_free,
	input  logic [WORD_BITS-1:0] lane_en,
	output scan_res_t            res
);

	logic [2*WORD_BITS-1:0] win;
	logic [WORD_BITS-1:0]   run_end;

	assign win = {cur_free, prev_free};

	// run ending at lane j may reach back into the previous word
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			run_end[j] = (&win[WORD_BITS + j -: SECTORS_PER_PAGE]) & lane_en[j];
		end
	end

	always_comb begin
		res.hit = |run_end;
		res.pos = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (run_end[j]) begin
				res.pos = WORD_LSB'(j);
			end
		end
	end

endmodule

// ===== hw/rtl/swap_slot_bitmap_allocator_top.sv =====
// swap slot bitmap allocator: first-fit page slot allocate and free over a used map
//
//  channel   ports                                   transfer
//  command   start busy func slot_index              start high while busy low
//  result    done status sector_index                done high, one cycle
//  config    swap_sectors_we swap_sectors_wdata      swap_sectors_we high
//
// the used map sits in one single-port memory of 64-bit words, one word read a cycle
// allocate: scan the map words in order until a free run of a page ends, then read and
//   write the one or two words that the run covers
// no free run: reported once the last word is scanned; free: read, check, write of one or two
//   words; out of range, or a device shorter than a page: reported straight from idle
// after reset a clearing pass writes ceil(MAX_SECTORS/64) words, one a cycle, busy high
// results cannot be stalled; a new command is taken in the cycle its predecessor reports
module swap_slot_bitmap_allocator_top
	import ssba_pkg::*;
#(
	parameter int MAX_SECTORS      = 8192,
	parameter int SECTORS_PER_PAGE = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [INDEX_W-1:0] slot_index,
	output logic               done,
	output logic [1:0]         status,
	output logic [INDEX_W-1:0] sector_index,
	input  logic               swap_sectors_we,
	input  logic [SWAP_W-1:0]  swap_sectors_wdata
);

	localparam int WB        = WORD_BITS;
	localparam int WL        = WORD_LSB;
	localparam int NUM_WORDS = (MAX_SECTORS + WB - 1) / WB;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int SW        = AW + WL;
	localparam int MAXW      = $clog2(MAX_SECTORS + 1);
	localparam int NW        = (MAXW > SWAP_W) ? MAXW : SWAP_W;

	localparam logic [NW-1:0]     MAX_N    = NW'(MAX_SECTORS);
	localparam logic [SWAP_W-1:0] SPP_N    = SWAP_W'(SECTORS_PER_PAGE);
	localparam logic [AW-1:0]     LAST_MEM = AW'(NUM_WORDS - 1);
	localparam logic [2*WB-1:0]   RUN_MASK =
		{{(2*WB-SECTORS_PER_PAGE){1'b0}}, {SECTORS_PER_PAGE{1'b1}}};

	state_t             state_q, state_d;
	logic [SWAP_W-1:0]  swap_q;
	logic               func_q;
	logic [SW-1:0]      start_q;
	logic [AW-1:0]      last_q;
	logic [AW-1:0]      issue_q;
	logic               issue_done_q;
	logic               pend_s1;
	logic [AW-1:0]      word_s1;
	logic [WB-1:0]      prev_free_q;
	logic [WB-1:0]      w0_q, w1_q;
	logic [AW-1:0]      clr_q;
	logic               done_q;
	status_t            status_q;
	logic [INDEX_W-1:0] index_q;

	logic [SWAP_W-1:0]  n_eff;
	logic               n_short;
	logic               free_err;
	logic [SWAP_W:0]    words_n;
	logic [AW-1:0]      last_word;
	logic [WB-1:0]      lane_en;
	logic [WB-1:0]      cur_free;
	scan_res_t          scan_res;
	logic [SW-1:0]      found_start;
	logic [AW-1:0]      addr_a, addr_b;
	logic [2*WB-1:0]    win_mask;
	logic [WB-1:0]      m0, m1;
	logic               need2;
	logic               all_used;
	logic [WB-1:0]      wdata0, wdata1;

	logic               mem_en, mem_we;
	logic [AW-1:0]      mem_addr;
	logic [WB-1:0]      mem_wdata, mem_rdata;

	// effective sector count, saturated to the store
	assign n_eff    = (NW'(swap_q) > MAX_N) ? MAX_N[SWAP_W-1:0] : swap_q;
	assign n_short  = n_eff < SPP_N;
	assign free_err = n_short || (SWAP_W'(slot_index) > (n_eff - SPP_N));
	assign words_n  = ((SWAP_W+1)'(n_eff) + (SWAP_W+1)'(WB - 1)) >> WL;
	assign last_word = AW'(words_n - (SWAP_W+1)'(1));

	assign lane_en  = ((word_s1 == last_q) && (n_eff[WL-1:0] != '0)) ?
		lane_mask(n_eff[WL-1:0]) : {WB{1'b1}};
	assign cur_free = ~mem_rdata;

	ssba_scan #(
		.SECTORS_PER_PAGE(SECTORS_PER_PAGE)
	) u_scan (
		.prev_free(prev_free_q),
		.cur_free (cur_free),
		.lane_en  (lane_en),
		.res      (scan_res)
	);

	assign found_start = {word_s1, scan_res.pos} - SW'(SECTORS_PER_PAGE) + SW'(1);

	// the run spans at most two words
	assign addr_a   = start_q[SW-1:WL];
	assign addr_b   = addr_a + AW'(1);
	assign win_mask = RUN_MASK << start_q[WL-1:0];
	assign m0       = win_mask[WB-1:0];
	assign m1       = win_mask[2*WB-1:WB];
	assign need2    = |m1;
	assign all_used = ((w0_q & m0) == m0) && ((w1_q & m1) == m1);
	assign wdata0   = (func_q == FUNC_ALLOC) ? (w0_q | m0) : (w0_q & ~m0);
	assign wdata1   = (func_q == FUNC_ALLOC) ? (w1_q | m1) : (w1_q & ~m1);

	ssba_mem #(
		.DEPTH(NUM_WORDS),
		.AW   (AW),
		.DW   (WB)
	) u_mem (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_MEM) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (func == FUNC_ALLOC) begin
						state_d = n_short ? S_IDLE : S_SCAN;
					end else begin
						state_d = free_err ? S_IDLE : S_RD0;
					end
				end
			end
			S_SCAN: begin
				if (pend_s1) begin
					if (scan_res.hit) begin
						state_d = S_RD0;
					end else if (word_s1 == last_q) begin
						state_d = S_IDLE;
					end
				end
			end
			S_RD0: state_d = S_RD1;
			S_RD1: state_d = need2 ? S_RD2 : S_CHK;
			S_RD2: state_d = S_CHK;
			S_CHK: state_d = ((func_q == FUNC_ALLOC) || all_used) ? S_WR0 : S_IDLE;
			S_WR0: state_d = need2 ? S_WR1 : S_IDLE;
			S_WR1: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = addr_a;
		mem_wdata = wdata0;
		unique case (state_q)
			S_CLEAR: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			S_SCAN: begin
				mem_en   = !issue_done_q;
				mem_addr = issue_q;
			end
			S_RD0: begin
				mem_en = 1'b1;
			end
			S_RD1: begin
				mem_en   = need2;
				mem_addr = addr_b;
			end
			S_WR0: begin
				mem_en = 1'b1;
				mem_we = 1'b1;
			end
			S_WR1: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = addr_b;
				mem_wdata = wdata1;
			end
			S_IDLE, S_RD2, S_CHK: begin
				mem_en = 1'b0;
			end
			default: begin
				mem_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			swap_q       <= SWAP_SECTORS_RESET;
			clr_q        <= '0;
			done_q       <= 1'b0;
			pend_s1      <= 1'b0;
			issue_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (swap_sectors_we) swap_q <= swap_sectors_wdata;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				S_IDLE: begin
					if (start) begin
						func_q       <= func;
						start_q      <= SW'(slot_index);
						last_q       <= last_word;
						issue_q      <= '0;
						issue_done_q <= 1'b0;
						pend_s1      <= 1'b0;
						prev_free_q  <= '0;
						if ((func == FUNC_ALLOC) && n_short) begin
							done_q   <= 1'b1;
							status_q <= ST_NO_SPACE;
							index_q  <= '0;
						end else if ((func == FUNC_FREE) && free_err) begin
							done_q   <= 1'b1;
							status_q <= ST_RANGE;
							index_q  <= '0;
						end
					end
				end
				S_SCAN: begin
					pend_s1 <= !issue_done_q;
					word_s1 <= issue_q;
					if (!issue_done_q) begin
						if (issue_q == last_q) begin
							issue_done_q <= 1'b1;
						end else begin
							issue_q <= issue_q + AW'(1);
						end
					end
					if (pend_s1) begin
						if (scan_res.hit) begin
							start_q <= found_start;
						end else begin
							prev_free_q <= cur_free;
							if (word_s1 == last_q) begin
								done_q   <= 1'b1;
								status_q <= ST_NO_SPACE;
								index_q  <= '0;
							end
						end
					end
				end
				S_RD1: begin
					w0_q <= mem_rdata;
				end
				S_RD2: begin
					w1_q <= mem_rdata;
				end
				S_CHK: begin
					if (!((func_q == FUNC_ALLOC) || all_used)) begin
						done_q   <= 1'b1;
						status_q <= ST_UNUSED;
						index_q  <= '0;
					end
				end
				S_WR0: begin
					if (!need2) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						index_q  <= (func_q == FUNC_ALLOC) ? INDEX_W'(start_q) : '0;
					end
				end
				S_WR1: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					index_q  <= (func_q == FUNC_ALLOC) ? INDEX_W'(start_q) : '0;
				end
				S_RD0: begin
					pend_s1 <= 1'b0;
				end
				default: begin
					pend_s1 <= 1'b0;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign sector_index = index_q;

endmodule

// ===== hw/rtl/ssba_checker.sv =====
// port-level checker of the swap slot bitmap allocator, bound to the top level
`include "swap_slot_bitmap_allocator_top_assert.svh"

module ssba_checker
	import ssba_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               func,
	input logic               done,
	input logic [1:0]         status,
	input logic [INDEX_W-1:0] sector_index
);

	// every result follows an op in flight or a transfer just taken
	`SSBA_ASSERT_IMP(a_done_cause, clk, arst_n, done, $past(busy || start))

	// only a good allocate carries a start index
	`SSBA_ASSERT_IMP(a_idx_zero, clk, arst_n, done && (status != ST_OK), sector_index == '0)

	// a taken command either works on or reports at once
	`SSBA_ASSERT_NXT(a_accept_prog, clk, arst_n, start && !busy, busy || done)

	// a range error is reported straight after a free transfer
	`SSBA_ASSERT_IMP(a_range_free, clk, arst_n, done && (status == ST_RANGE), $past(start && !busy && (func == FUNC_FREE)))

endmodule

bind swap_slot_bitmap_allocator_top ssba_checker u_ssba_checker (.*);

// ===== sim/swap_slot_bitmap_allocator_checker.sv =====
// checker for the swap slot bitmap allocator: mirrors the used map and compares every result
module swap_slot_bitmap_allocator_checker
	import ssba_pkg::*;
#(
	parameter int MAX_SECTORS      = 8192,
	parameter int SECTORS_PER_PAGE = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               func,
	input  logic [INDEX_W-1:0] slot_index,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic [INDEX_W-1:0] sector_index,
	input  logic               swap_sectors_we,
	input  logic [SWAP_W-1:0]  swap_sectors_wdata,
	output int                 fail_count,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t            st;
		logic [INDEX_W-1:0] idx;
	} slot_reply_t;

	bit [MAX_SECTORS-1:0] sector_busy_map;
	logic [SWAP_W-1:0]    sector_count;
	slot_reply_t          reply_q[$];

	// first-fit allocate or checked free against the mirrored map
	function automatic slot_reply_t serve_slot(input logic op, input logic [INDEX_W-1:0] slot);
		slot_reply_t r;
		int          n;
		int          run;
		int          first;
		bit          all_set;
		r.st  = ST_OK;
		r.idx = '0;
		n     = (int'(sector_count) > MAX_SECTORS) ? MAX_SECTORS : int'(sector_count);
		if (op == FUNC_ALLOC) begin
			run   = 0;
			first = -1;
			for (int i = 0; i < n && first < 0; i++) begin
				if (sector_busy_map[i])
					run = 0;
				else
					run++;
				if (run >= SECTORS_PER_PAGE)
					first = i + 1 - SECTORS_PER_PAGE;
			end
			if (first < 0) begin
				r.st = ST_NO_SPACE;
			end else begin
				for (int k = 0; k < SECTORS_PER_PAGE; k++)
					sector_busy_map[first + k] = 1'b1;
				r.idx = INDEX_W'(first);
			end
		end else if (SECTORS_PER_PAGE > n || int'(slot) > n - SECTORS_PER_PAGE) begin
			r.st = ST_RANGE;
		end else begin
			all_set = 1'b1;
			for (int k = 0; k < SECTORS_PER_PAGE; k++)
				if (!sector_busy_map[int'(slot) + k])
					all_set = 1'b0;
			if (all_set) begin
				for (int k = 0; k < SECTORS_PER_PAGE; k++)
					sector_busy_map[int'(slot) + k] = 1'b0;
			end else begin
				r.st = ST_UNUSED;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_reply_t want;
		if (!arst_n) begin
			sector_busy_map = '0;
			sector_count    = SWAP_SECTORS_RESET;
			reply_q.delete();
			fail_count      = 0;
			outstanding     <= 0;
		end else begin
			// the result transfer is compared before a command taken on the same edge
			if (done) begin
				if (reply_q.size() == 0) begin
					$error("result with nothing pending: status %0d, sector_index %0d",
						status, sector_index);
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					if (status !== want.st) begin
						$error("status mismatch: expected %0d, actual %0d", want.st, status);
						fail_count++;
					end
					if (sector_index !== want.idx) begin
						$error("sector_index mismatch: expected %0d, actual %0d",
							want.idx, sector_index);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				reply_q.push_back(serve_slot(func, slot_index));
			if (swap_sectors_we)
				sector_count = swap_sectors_wdata;
			outstanding <= reply_q.size();
		end
	end

endmodule

// ===== sim/swap_slot_bitmap_allocator_top_tb.sv =====
// testbench top for the swap slot bitmap allocator: stimulus, clock, reset and verdict
module swap_slot_bitmap_allocator_top_tb
	import ssba_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SECTORS      = 8192;
	localparam int SECTORS_PER_PAGE = 8;
	localparam int CYCLE_LIMIT      = 1000000;
	localparam int PHASES           = 11;

	logic               clk;
	logic               arst_n             = 1'b0;
	logic               start              = 1'b0;
	logic               busy;
	logic               func               = FUNC_ALLOC;
	logic [INDEX_W-1:0] slot_index         = '0;
	logic               done;
	logic [1:0]         status;
	logic [INDEX_W-1:0] sector_index;
	logic               swap_sectors_we    = 1'b0;
	logic [SWAP_W-1:0]  swap_sectors_wdata = '0;
	int                 fail_count;
	int                 outstanding;
	int                 cycle_count        = 0;

	// operations in flight and page slots handed out, used to aim frees at live runs
	logic               ops_in_flight[$];
	logic [INDEX_W-1:0] live_slots[$];

	swap_slot_bitmap_allocator_top #(
		.MAX_SECTORS      (MAX_SECTORS),
		.SECTORS_PER_PAGE (SECTORS_PER_PAGE)
	) u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.func               (func),
		.slot_index         (slot_index),
		.done               (done),
		.status             (status),
		.sector_index       (sector_index),
		.swap_sectors_we    (swap_sectors_we),
		.swap_sectors_wdata (swap_sectors_wdata)
	);

	swap_slot_bitmap_allocator_checker #(
		.MAX_SECTORS      (MAX_SECTORS),
		.SECTORS_PER_PAGE (SECTORS_PER_PAGE)
	) u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.func               (func),
		.slot_index         (slot_index),
		.done               (done),
		.status             (status),
		.sector_index       (sector_index),
		.swap_sectors_we    (swap_sectors_we),
		.swap_sectors_wdata (swap_sectors_wdata),
		.fail_count         (fail_count),
		.outstanding        (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		logic was_alloc;
		if (arst_n && done && ops_in_flight.size() != 0) begin
			was_alloc = (ops_in_flight.pop_front() == FUNC_ALLOC);
			if (was_alloc && status == ST_OK)
				live_slots.push_back(sector_index);
		end
	end

	task automatic issue(input logic op, input logic [INDEX_W-1:0] slot);
		start      <= 1'b1;
		func       <= op;
		slot_index <= slot;
		do @(posedge clk); while (busy);
		ops_in_flight.push_back(op);
	endtask

	// wait until every result is back and the block is idle
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (busy || outstanding != 0);
	endtask

	task automatic write_sectors(input logic [SWAP_W-1:0] count);
		settle();
		swap_sectors_we    <= 1'b1;
		swap_sectors_wdata <= count;
		@(posedge clk);
		swap_sectors_we    <= 1'b0;
	endtask

	initial begin : stimulus
		int                 phase_sectors[PHASES];
		int                 phase_items[PHASES];
		int                 n_eff;
		int                 alloc_pct;
		int                 pick;
		int                 j;
		bit                 idling;
		logic [INDEX_W-1:0] slot;

		phase_sectors = '{64, 9, 200, 8192, 16, 1000, 130, 16383, 40, 520, 8};
		phase_items   = '{300, 80, 250, 120, 120, 250, 200, 100, 250, 200, 80};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// the clearing pass after reset keeps busy high
		settle();

		// full device: holes, double free, partly unused run, edge of the range
		issue(FUNC_ALLOC, 13'h1FFF);
		issue(FUNC_ALLOC, 13'h0000);
		issue(FUNC_ALLOC, 13'h0000);
		issue(FUNC_FREE, 13'd8);
		issue(FUNC_FREE, 13'd8);
		issue(FUNC_FREE, 13'd4);
		issue(FUNC_FREE, 13'd8184);
		issue(FUNC_FREE, 13'd8185);
		issue(FUNC_FREE, 13'h1FFF);
		issue(FUNC_ALLOC, 13'h0000);
		issue(FUNC_FREE, 13'd0);
		issue(FUNC_FREE, 13'd8);
		issue(FUNC_FREE, 13'd16);

		// empty device and one shorter than a page
		write_sectors(14'd0);
		issue(FUNC_ALLOC, 13'h0000);
		issue(FUNC_FREE, 13'd0);
		write_sectors(14'd7);
		issue(FUNC_ALLOC, 13'h0000);
		issue(FUNC_FREE, 13'd0);

		// count above the map saturates
		write_sectors(14'h3FFF);
		issue(FUNC_ALLOC, 13'h0000);
		issue(FUNC_FREE, 13'd0);

		// exactly one page
		write_sectors(14'd8);
		issue(FUNC_ALLOC, 13'h0000);
		issue(FUNC_ALLOC, 13'h0000);
		issue(FUNC_FREE, 13'd1);
		issue(FUNC_FREE, 13'd0);

		for (int p = 0; p < PHASES; p++) begin
			write_sectors(SWAP_W'(phase_sectors[p]));
			n_eff     = (phase_sectors[p] > MAX_SECTORS) ? MAX_SECTORS : phase_sectors[p];
			alloc_pct = $urandom_range(35, 65);
			idling    = 1'b0;
			for (int i = 0; i < phase_items[p]; i++) begin
				if (i % 40 == 0)
					idling = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
				if (idling && $urandom_range(0, 3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 5)) @(posedge clk);
				end
				if ($urandom_range(0, 99) < alloc_pct) begin
					issue(FUNC_ALLOC, INDEX_W'($urandom_range(0, MAX_SECTORS - 1)));
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 65 && live_slots.size() != 0) begin
						// well-formed: give back a run that was handed out
						j    = $urandom_range(0, live_slots.size() - 1);
						slot = live_slots[j];
						live_slots.delete(j);
					end else if (pick < 80 && live_slots.size() != 0) begin
						// run straddling a live slot and whatever follows it
						j    = $urandom_range(0, live_slots.size() - 1);
						slot = INDEX_W'(live_slots[j] + $urandom_range(1, SECTORS_PER_PAGE - 1));
					end else if (pick < 90) begin
						slot = INDEX_W'(n_eff - int'($urandom_range(1, 12)));
					end else begin
						slot = INDEX_W'($urandom_range(0, MAX_SECTORS - 1));
					end
					issue(FUNC_FREE, slot);
				end
			end
		end

		settle();
		repeat (16) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
